// ===== design/pfi_pkg.sv =====
`timescale 1ns / 1ps

package pfi_pkg;

  localparam int unsigned MAX_WIDTH_DEF = 64;
  localparam int unsigned ARG_BITS_DEF  = 32;
  // 32-bit octal needs 11 digits; keep one spare slot
  localparam int unsigned DIGIT_SLOTS   = 12;

  // floor(v / 10) == (v * RECIP_10) >> 35 for every 32-bit v
  localparam logic [31:0] RECIP_10 = 32'hCCCC_CCCD;
  localparam int unsigned RECIP_SHIFT = 35;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_LOWER_A = 8'h61;

  localparam logic [7:0] CH_MOD_F = 8'h46;
  localparam logic [7:0] CH_MOD_N = 8'h4E;
  localparam logic [7:0] CH_MOD_L = 8'h6C;
  localparam logic [7:0] CH_MOD_H = 8'h68;

  localparam logic [7:0] CH_CONV_D  = 8'h64;
  localparam logic [7:0] CH_CONV_I  = 8'h69;
  localparam logic [7:0] CH_CONV_U  = 8'h75;
  localparam logic [7:0] CH_CONV_O  = 8'h6F;
  localparam logic [7:0] CH_CONV_X  = 8'h78;
  localparam logic [7:0] CH_CONV_UX = 8'h58;
  localparam logic [7:0] CH_CONV_P  = 8'h70;
  localparam logic [7:0] CH_CONV_N  = 8'h6E;
  localparam logic [7:0] CH_CONV_C  = 8'h63;

  typedef enum logic [1:0] {
    RADIX_8,
    RADIX_10,
    RADIX_16
  } radix_e;

  typedef struct packed {
    logic        start;
    radix_e      radix;
    logic [31:0] value;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quot;
    logic [3:0]  digit;
  } div_rsp_t;

endpackage

// ===== design/pfi_divider.sv =====
`timescale 1ns / 1ps

module pfi_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pfi_pkg::div_req_t req_i,
  output pfi_pkg::div_rsp_t rsp_o
);

  logic [63:0]     prod;
  logic [31:0]     quot1;
  logic [31:0]     back;
  logic [31:0]     diff;

  logic            vld1_q;
  logic [31:0]     val1_q;
  logic [31:0]     quot1_q;
  pfi_pkg::radix_e radix1_q;

  logic            done_q;
  logic [31:0]     quot_q;
  logic [3:0]      digit_q;

  // Stage 1: quotient by shift or reciprocal multiply
  always_comb begin
    prod = {32'd0, req_i.value} * {32'd0, pfi_pkg::RECIP_10};
    case (req_i.radix)
      pfi_pkg::RADIX_8:  quot1 = req_i.value >> 3;
      pfi_pkg::RADIX_16: quot1 = req_i.value >> 4;
      default:           quot1 = 32'(prod[63:pfi_pkg::RECIP_SHIFT]);
    endcase
  end

  // Stage 2: remainder from quotient times radix
  always_comb begin
    case (radix1_q)
      pfi_pkg::RADIX_8:  back = quot1_q << 3;
      pfi_pkg::RADIX_16: back = quot1_q << 4;
      default:           back = (quot1_q << 3) + (quot1_q << 1);
    endcase
    diff = val1_q - back;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      vld1_q <= req_i.start;
      done_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      val1_q   <= req_i.value;
      quot1_q  <= quot1;
      radix1_q <= req_i.radix;
    end
    if (vld1_q) begin
      quot_q  <= quot1_q;
      digit_q <= diff[3:0];
    end
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.quot  = quot_q;
  assign rsp_o.digit = digit_q;

endmodule

// ===== design/printf_integer_formatter.sv =====
`timescale 1ns / 1ps

// Integer printf formatter. Each input item is one format-string byte (tdata[7:0]) plus one
// 32-bit argument word (tdata[39:8]); each output item is one character with tlast marking
// the final character caused by that input item. Plain bytes and "%%" are loaded straight
// into the output register; flag, width and modifier bytes are consumed silently. A numeric
// conversion runs the value through one two-stage radix divider, one digit per pass (up to
// eleven digits), then emits sign, padding and digits at one character per cycle while the
// output is not stalled, through a single output register. A conversion keeps the input
// closed through its divider passes, one planning step, its characters and a step-over for
// each empty sign or padding phase. The input is not ready while a conversion is in
// progress or while the output register is stalled.
// Width saturates at MAX_WIDTH, which also bounds the characters of one item.
module printf_integer_formatter #(
  parameter int unsigned MAX_WIDTH = pfi_pkg::MAX_WIDTH_DEF,
  parameter int unsigned ARG_BITS  = pfi_pkg::ARG_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,   // [7:0] format_char, [39:8] arg_value
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [7:0] out_char
  output logic        m_axis_tlast_o    // last_of_run
);

  localparam int unsigned CntW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned AccW = CntW + 4;
  localparam logic [31:0] ArgMask = 32'((64'd1 << ARG_BITS) - 64'd1);

  typedef enum logic [1:0] {
    PH_WAIT,
    PH_FLAGS,
    PH_WIDTH,
    PH_MODS
  } phase_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_WAIT,
    S_PLAN,
    S_SIGN_A,
    S_PAD_L,
    S_SIGN_B,
    S_BODY,
    S_PAD_R
  } state_e;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] base;
    base = upper ? pfi_pkg::CH_UPPER_A : pfi_pkg::CH_LOWER_A;
    if (d < 4'd10) begin
      return pfi_pkg::CH_ZERO + 8'(d);
    end
    return base + 8'(d) - 8'd10;
  endfunction

  // Control state
  state_e          state_q, state_d;
  phase_e          phase_q, phase_d;
  logic            lj_q, lj_d;
  logic            zp_q, zp_d;
  logic            sh_q, sh_d;
  logic            lg_q, lg_d;
  logic [CntW-1:0] fw_q, fw_d;
  logic            neg_q, neg_d;
  pfi_pkg::radix_e radix_q, radix_d;
  logic            upper_q, upper_d;
  logic            is_char_q, is_char_d;
  logic [3:0]      nd_q, nd_d;
  logic [CntW-1:0] padl_q, padl_d;
  logic [CntW-1:0] padr_q, padr_d;
  logic [3:0]      body_q, body_d;
  logic [CntW-1:0] left_q, left_d;
  logic            sign_a_q, sign_a_d;
  logic            sign_b_q, sign_b_d;
  logic            pad_zero_q, pad_zero_d;
  logic            oval_q, oval_d;
  logic [7:0]      ochar_q, ochar_d;
  logic            olast_q, olast_d;

  // Payload
  logic [31:0]     val_q, val_d;
  logic            val_load;
  logic [7:0]      char_q;
  logic            char_load;
  logic [3:0]      digits_q [pfi_pkg::DIGIT_SLOTS];
  logic            dig_we;

  pfi_pkg::div_req_t div_req;
  pfi_pkg::div_rsp_t div_rsp;

  logic [7:0]      fc;
  logic [31:0]     arg;
  logic            accept;
  logic            slot_free;
  logic            is_digit;
  logic            is_mod;
  logic            is_num;
  logic            is_signed;
  logic [AccW-1:0] width_acc;
  logic [CntW-1:0] width_sat;
  logic [31:0]     mask;
  logic            sign_bit;
  logic [31:0]     v_abs;
  logic            v_neg;
  logic            emit;
  logic [7:0]      emit_char;
  logic [CntW-1:0] actual;
  logic [CntW-1:0] pad_n;
  logic            pad_gt;
  logic [3:0]      body_n;
  logic [CntW-1:0] total;
  logic [3:0]      nd_inc;

  assign fc        = s_axis_tdata_i[7:0];
  assign arg       = s_axis_tdata_i[39:8];
  assign slot_free = !oval_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == S_IDLE) && slot_free;
  assign accept    = s_axis_tvalid_i && s_axis_tready_o;

  // Byte classes
  assign is_digit = (fc >= pfi_pkg::CH_ZERO) && (fc <= pfi_pkg::CH_NINE);
  assign is_mod   = (fc == pfi_pkg::CH_MOD_F) || (fc == pfi_pkg::CH_MOD_N) ||
                    (fc == pfi_pkg::CH_MOD_L) || (fc == pfi_pkg::CH_MOD_H);
  assign is_signed = (fc == pfi_pkg::CH_CONV_D) || (fc == pfi_pkg::CH_CONV_I);
  assign is_num   = is_signed || (fc == pfi_pkg::CH_CONV_U) || (fc == pfi_pkg::CH_CONV_O) ||
                    (fc == pfi_pkg::CH_CONV_X) || (fc == pfi_pkg::CH_CONV_UX) ||
                    (fc == pfi_pkg::CH_CONV_P) || (fc == pfi_pkg::CH_CONV_N);

  // Width accumulate: 10 * width + digit, saturated
  assign width_acc = (AccW'(fw_q) << 3) + (AccW'(fw_q) << 1) +
                     AccW'(fc[3:0]);
  assign width_sat = (width_acc > AccW'(MAX_WIDTH)) ? CntW'(MAX_WIDTH) : width_acc[CntW-1:0];

  // Argument size and magnitude; l wins over h
  always_comb begin
    if (lg_q) begin
      mask     = '1;
      sign_bit = arg[31];
    end else if (sh_q) begin
      mask     = 32'h0000_FFFF;
      sign_bit = arg[15];
    end else begin
      mask     = ArgMask;
      sign_bit = arg[ARG_BITS-1];
    end
    v_neg = is_signed && sign_bit;
    v_abs = v_neg ? ((~(arg & mask) + 32'd1) & mask) : (arg & mask);
  end

  // Emission plan
  always_comb begin
    actual = is_char_q ? CntW'(1) : (CntW'(nd_q) + CntW'(neg_q));
    pad_gt = fw_q > actual;
    pad_n  = fw_q - actual;
    body_n = is_char_q ? {3'd0, (char_q != 8'd0)} : nd_q;
    total  = (pad_gt ? pad_n : '0) + CntW'(body_n) + CntW'(neg_q);
  end

  assign nd_inc = nd_q + 4'd1;

  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    lj_d       = lj_q;
    zp_d       = zp_q;
    sh_d       = sh_q;
    lg_d       = lg_q;
    fw_d       = fw_q;
    neg_d      = neg_q;
    radix_d    = radix_q;
    upper_d    = upper_q;
    is_char_d  = is_char_q;
    nd_d       = nd_q;
    padl_d     = padl_q;
    padr_d     = padr_q;
    body_d     = body_q;
    left_d     = left_q;
    sign_a_d   = sign_a_q;
    sign_b_d   = sign_b_q;
    pad_zero_d = pad_zero_q;
    val_d      = val_q;
    val_load   = 1'b0;
    char_load  = 1'b0;
    dig_we     = 1'b0;
    emit       = 1'b0;
    emit_char  = fc;
    div_req.start = 1'b0;
    div_req.radix = radix_q;
    div_req.value = val_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (fc == 8'd0) begin
            // end of string: drop any partial spec
            phase_d = PH_WAIT;
            lj_d = 1'b0; zp_d = 1'b0; sh_d = 1'b0; lg_d = 1'b0; fw_d = '0;
          end else if (phase_q == PH_WAIT) begin
            if (fc == pfi_pkg::CH_PERCENT) begin
              phase_d = PH_FLAGS;
            end else begin
              emit = 1'b1;
            end
          end else if (phase_q == PH_FLAGS && fc == pfi_pkg::CH_PERCENT) begin
            emit = 1'b1;
            phase_d = PH_WAIT;
            lj_d = 1'b0; zp_d = 1'b0; sh_d = 1'b0; lg_d = 1'b0; fw_d = '0;
          end else if (phase_q == PH_FLAGS && fc == pfi_pkg::CH_MINUS) begin
            if (lj_q) begin
              // repeated minus aborts the spec
              phase_d = PH_WAIT;
              lj_d = 1'b0; zp_d = 1'b0; sh_d = 1'b0; lg_d = 1'b0; fw_d = '0;
            end else begin
              lj_d = 1'b1;
            end
          end else if (phase_q == PH_FLAGS && fc == pfi_pkg::CH_ZERO) begin
            zp_d    = 1'b1;
            phase_d = PH_WIDTH;
          end else if (phase_q != PH_MODS && is_digit) begin
            fw_d    = width_sat;
            phase_d = PH_WIDTH;
          end else if (is_mod) begin
            if (fc == pfi_pkg::CH_MOD_L) begin
              lg_d = 1'b1;
            end
            if (fc == pfi_pkg::CH_MOD_H) begin
              sh_d = 1'b1;
            end
            phase_d = PH_MODS;
          end else if (fc == pfi_pkg::CH_CONV_C) begin
            is_char_d = 1'b1;
            neg_d     = 1'b0;
            char_load = 1'b1;
            state_d   = S_PLAN;
          end else if (is_num) begin
            is_char_d = 1'b0;
            neg_d     = v_neg;
            upper_d   = (fc == pfi_pkg::CH_CONV_UX);
            if (fc == pfi_pkg::CH_CONV_O) begin
              radix_d = pfi_pkg::RADIX_8;
            end else if (is_signed || fc == pfi_pkg::CH_CONV_U) begin
              radix_d = pfi_pkg::RADIX_10;
            end else begin
              radix_d = pfi_pkg::RADIX_16;
            end
            val_d    = v_abs;
            val_load = 1'b1;
            nd_d     = 4'd0;
            state_d  = S_DIV;
          end else begin
            // unknown conversion: reset the parser silently
            phase_d = PH_WAIT;
            lj_d = 1'b0; zp_d = 1'b0; sh_d = 1'b0; lg_d = 1'b0; fw_d = '0;
          end
        end
      end

      S_DIV: begin
        div_req.start = 1'b1;
        state_d       = S_WAIT;
      end

      S_WAIT: begin
        if (div_rsp.done) begin
          dig_we   = 1'b1;
          val_d    = div_rsp.quot;
          val_load = 1'b1;
          nd_d     = nd_inc;
          if (div_rsp.quot == 32'd0 || nd_inc == 4'(pfi_pkg::DIGIT_SLOTS)) begin
            state_d = S_PLAN;
          end else begin
            state_d = S_DIV;
          end
        end
      end

      S_PLAN: begin
        sign_a_d   = neg_q && zp_q;
        sign_b_d   = neg_q && !zp_q;
        pad_zero_d = zp_q && !is_char_q;
        padl_d     = (pad_gt && !lj_q) ? pad_n : '0;
        padr_d     = (pad_gt && lj_q) ? pad_n : '0;
        body_d     = body_n;
        left_d     = total;
        state_d    = (total == '0) ? S_IDLE : S_SIGN_A;
        phase_d    = PH_WAIT;
        lj_d = 1'b0; zp_d = 1'b0; sh_d = 1'b0; lg_d = 1'b0; fw_d = '0;
      end

      S_SIGN_A: begin
        if (!sign_a_q) begin
          state_d = S_PAD_L;
        end else if (slot_free) begin
          emit      = 1'b1;
          emit_char = pfi_pkg::CH_MINUS;
          state_d   = S_PAD_L;
        end
      end

      S_PAD_L: begin
        if (padl_q == '0) begin
          state_d = S_SIGN_B;
        end else if (slot_free) begin
          emit      = 1'b1;
          emit_char = pad_zero_q ? pfi_pkg::CH_ZERO : pfi_pkg::CH_SPACE;
          padl_d    = padl_q - CntW'(1);
        end
      end

      S_SIGN_B: begin
        if (!sign_b_q) begin
          state_d = S_BODY;
        end else if (slot_free) begin
          emit      = 1'b1;
          emit_char = pfi_pkg::CH_MINUS;
          state_d   = S_BODY;
        end
      end

      S_BODY: begin
        if (body_q == 4'd0) begin
          state_d = S_PAD_R;
        end else if (slot_free) begin
          emit      = 1'b1;
          emit_char = is_char_q ? char_q : digit_char(digits_q[body_q - 4'd1], upper_q);
          body_d    = body_q - 4'd1;
        end
      end

      S_PAD_R: begin
        if (padr_q == '0) begin
          state_d = S_IDLE;
        end else if (slot_free) begin
          emit      = 1'b1;
          emit_char = pfi_pkg::CH_SPACE;
          padr_d    = padr_q - CntW'(1);
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Count down the run; leave as soon as its last character is out
    if (emit && state_q != S_IDLE) begin
      left_d = left_q - CntW'(1);
      if (left_q == CntW'(1)) begin
        state_d = S_IDLE;
      end
    end

    // Output register: load on emit, drop once taken
    oval_d  = oval_q && !m_axis_tready_i;
    ochar_d = ochar_q;
    olast_d = olast_q;
    if (emit) begin
      oval_d  = 1'b1;
      ochar_d = emit_char;
      olast_d = (state_q == S_IDLE) || (left_q == CntW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      phase_q    <= PH_WAIT;
      lj_q       <= 1'b0;
      zp_q       <= 1'b0;
      sh_q       <= 1'b0;
      lg_q       <= 1'b0;
      fw_q       <= '0;
      neg_q      <= 1'b0;
      radix_q    <= pfi_pkg::RADIX_10;
      upper_q    <= 1'b0;
      is_char_q  <= 1'b0;
      nd_q       <= 4'd0;
      padl_q     <= '0;
      padr_q     <= '0;
      body_q     <= 4'd0;
      left_q     <= '0;
      sign_a_q   <= 1'b0;
      sign_b_q   <= 1'b0;
      pad_zero_q <= 1'b0;
      oval_q     <= 1'b0;
      ochar_q    <= 8'd0;
      olast_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      phase_q    <= phase_d;
      lj_q       <= lj_d;
      zp_q       <= zp_d;
      sh_q       <= sh_d;
      lg_q       <= lg_d;
      fw_q       <= fw_d;
      neg_q      <= neg_d;
      radix_q    <= radix_d;
      upper_q    <= upper_d;
      is_char_q  <= is_char_d;
      nd_q       <= nd_d;
      padl_q     <= padl_d;
      padr_q     <= padr_d;
      body_q     <= body_d;
      left_q     <= left_d;
      sign_a_q   <= sign_a_d;
      sign_b_q   <= sign_b_d;
      pad_zero_q <= pad_zero_d;
      oval_q     <= oval_d;
      ochar_q    <= ochar_d;
      olast_q    <= olast_d;
    end
  end

  // Value, character and digit store
  always_ff @(posedge clk_i) begin
    if (val_load) begin
      val_q <= val_d;
    end
    if (char_load) begin
      char_q <= arg[7:0];
    end
    if (dig_we) begin
      digits_q[nd_q] <= div_rsp.digit;
    end
  end

  pfi_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign m_axis_tvalid_o = oval_q;
  assign m_axis_tdata_o  = ochar_q;
  assign m_axis_tlast_o  = olast_q;

endmodule

// ===== design/pfi_checker.sv =====
`timescale 1ns / 1ps

module pfi_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid_i,
  input logic       s_axis_tready_o,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o,
  input logic       m_axis_tlast_o
);

  // Input is only taken when the output register can move
  a_ready_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o && m_axis_tvalid_o |-> m_axis_tready_i)
    else $error("input ready while output stalled");

  // A run in progress keeps the input closed
  a_busy_mid_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tlast_o |-> !s_axis_tready_o)
    else $error("input ready before run finished");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("stalled output item changed");

endmodule

bind printf_integer_formatter pfi_checker u_pfi_checker (.*);

// ===== test/printf_integer_formatter_test.sv =====
`timescale 1ns / 1ps

module printf_integer_formatter_test;

  localparam int unsigned RANDOM_ITEMS = 370;
  // Cycles with no item moving on either side before the run is declared hung.
  // The limit is well above the long receiver hold-off and a full conversion.
  localparam int unsigned IDLE_LIMIT   = 3000;
  localparam int unsigned HOLDOFF_LEN  = 300;
  localparam int unsigned DRAIN_CYCLES = 200;

  // Predict the text that each format byte produces and check it on the way out.
  class formatter_scoreboard;
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam int unsigned MAX_CHARS = pfi_pkg::MAX_WIDTH_DEF;

    typedef struct packed {
      logic [7:0] ch;
      logic       last;
    } out_char_t;

    out_char_t   expected_chars[$];
    logic [7:0]  line_chars[$];
    int unsigned error_count;
    int unsigned printed_count;

    // Parser state of the block
    logic [2:0]  parse_phase;
    logic        left_justify;
    logic        zero_pad;
    logic        short_mod;
    logic        long_mod;
    int unsigned field_width;

    function new();
      error_count = 0;
      printed_count = 0;
      clear_spec();
    endfunction

    function void clear_spec();
      parse_phase = 3'd0;
      left_justify = 1'b0;
      zero_pad = 1'b0;
      short_mod = 1'b0;
      long_mod = 1'b0;
      field_width = 0;
    endfunction

    // One item never produces more than MAX_CHARS characters
    function void put_char(logic [7:0] ch);
      if (line_chars.size() < MAX_CHARS) begin
        line_chars.push_back(ch);
      end
    endfunction

    function void put_run(logic [7:0] ch, int unsigned count);
      for (int unsigned i = 0; i < count; i++) begin
        put_char(ch);
      end
    endfunction

    function void format_char_conv(logic [31:0] arg);
      int unsigned given;
      given = field_width;
      // Right justify: spaces first, the zero flag does not apply here
      if (!left_justify && given > 1) begin
        put_run(pfi_pkg::CH_SPACE, given - 1);
        given = 1;
      end
      // A zero byte takes its slot in the width but prints nothing
      if (arg[7:0] != CH_NUL) begin
        put_char(arg[7:0]);
      end
      if (given > 1) begin
        put_run(pfi_pkg::CH_SPACE, given - 1);
      end
    endfunction

    function void format_number(logic [7:0] conv, logic [31:0] arg);
      int unsigned radix;
      int unsigned bits;
      int unsigned mask;
      int unsigned v;
      int unsigned d;
      int unsigned nd;
      int unsigned given;
      int unsigned actual;
      logic [7:0]  letter;
      logic [7:0]  digit_chars[12];
      logic        is_signed;
      logic        neg;
      is_signed = (conv == pfi_pkg::CH_CONV_D || conv == pfi_pkg::CH_CONV_I);
      if (conv == pfi_pkg::CH_CONV_O) begin
        radix = 8;
      end else if (is_signed || conv == pfi_pkg::CH_CONV_U) begin
        radix = 10;
      end else begin
        radix = 16;
      end
      letter = (conv == pfi_pkg::CH_CONV_UX) ? pfi_pkg::CH_UPPER_A : pfi_pkg::CH_LOWER_A;
      // l wins over h; without either the full argument width applies
      bits = long_mod ? 32 : (short_mod ? 16 : pfi_pkg::ARG_BITS_DEF);
      mask = (bits >= 32) ? 32'hFFFF_FFFF : ((32'd1 << bits) - 1);
      v = arg & mask;
      neg = 1'b0;
      if (is_signed && v[bits - 1]) begin
        neg = 1'b1;
        v = (~v + 1) & mask;
      end
      nd = 0;
      do begin
        d = v % radix;
        digit_chars[nd] = (d < 10) ? 8'(pfi_pkg::CH_ZERO + d) : 8'(d - 10 + letter);
        nd++;
        v = v / radix;
      end while (v != 0 && nd < pfi_pkg::DIGIT_SLOTS);

      given = field_width;
      actual = nd + (neg ? 1 : 0);
      // With zero padding the sign leads the zeroes
      if (neg && zero_pad) begin
        put_char(pfi_pkg::CH_MINUS);
      end
      if (!left_justify && given > actual) begin
        put_run(zero_pad ? pfi_pkg::CH_ZERO : pfi_pkg::CH_SPACE, given - actual);
        given = actual;
      end
      if (neg && !zero_pad) begin
        put_char(pfi_pkg::CH_MINUS);
      end
      for (int unsigned k = nd; k > 0; k--) begin
        put_char(digit_chars[k - 1]);
      end
      // Left justified padding is always spaces
      if (given > actual) begin
        put_run(pfi_pkg::CH_SPACE, given - actual);
      end
    endfunction

    // Advance the parser by one format byte and queue the characters it emits
    function void note_input(logic [7:0] fmt, logic [31:0] arg);
      logic [2:0] phase;
      logic       handled;
      phase = parse_phase;
      handled = 1'b0;
      line_chars.delete();

      // A zero byte ends the string in any phase
      if (fmt == CH_NUL || phase > 3'd3) begin
        clear_spec();
        return;
      end

      if (phase == 3'd0) begin
        if (fmt != pfi_pkg::CH_PERCENT) begin
          put_char(fmt);
        end else begin
          parse_phase = 3'd1;
        end
        handled = 1'b1;
      end

      if (!handled && phase == 3'd1) begin
        if (fmt == pfi_pkg::CH_PERCENT) begin
          put_char(fmt);
          clear_spec();
          handled = 1'b1;
        end else if (fmt == pfi_pkg::CH_MINUS) begin
          // A second minus drops the whole spec
          if (left_justify) begin
            clear_spec();
          end else begin
            left_justify = 1'b1;
          end
          handled = 1'b1;
        end else if (fmt == pfi_pkg::CH_ZERO) begin
          zero_pad = 1'b1;
          parse_phase = 3'd2;
          handled = 1'b1;
        end else begin
          phase = 3'd2;
        end
      end

      if (!handled && phase == 3'd2) begin
        if (fmt >= pfi_pkg::CH_ZERO && fmt <= pfi_pkg::CH_NINE) begin
          field_width = 10 * field_width + (fmt - pfi_pkg::CH_ZERO);
          if (field_width > pfi_pkg::MAX_WIDTH_DEF) begin
            field_width = pfi_pkg::MAX_WIDTH_DEF;
          end
          parse_phase = 3'd2;
          handled = 1'b1;
        end else begin
          phase = 3'd3;
        end
      end

      if (!handled && phase == 3'd3) begin
        if (fmt == pfi_pkg::CH_MOD_F || fmt == pfi_pkg::CH_MOD_N ||
            fmt == pfi_pkg::CH_MOD_L || fmt == pfi_pkg::CH_MOD_H) begin
          if (fmt == pfi_pkg::CH_MOD_L) begin
            long_mod = 1'b1;
          end
          if (fmt == pfi_pkg::CH_MOD_H) begin
            short_mod = 1'b1;
          end
          parse_phase = 3'd3;
          handled = 1'b1;
        end
      end

      // Anything left is a conversion; unknown ones just reset the parser
      if (!handled) begin
        case (fmt)
          pfi_pkg::CH_CONV_C: begin
            format_char_conv(arg);
          end
          pfi_pkg::CH_CONV_D, pfi_pkg::CH_CONV_I, pfi_pkg::CH_CONV_U,
          pfi_pkg::CH_CONV_O, pfi_pkg::CH_CONV_X, pfi_pkg::CH_CONV_UX,
          pfi_pkg::CH_CONV_P, pfi_pkg::CH_CONV_N: begin
            format_number(fmt, arg);
          end
          default: begin
          end
        endcase
        clear_spec();
      end

      foreach (line_chars[i]) begin
        expected_chars.push_back('{ch: line_chars[i], last: (i == line_chars.size() - 1)});
      end
    endfunction

    task report_mismatch(string msg);
      error_count++;
      if (printed_count < 40) begin
        printed_count++;
        $display("%0t ns: mismatch: %s", $time, msg);
      end
    endtask

    task check_output(logic [7:0] ch, logic last);
      out_char_t want;
      if (expected_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected char 0x%02h last=%0b", ch, last));
      end else begin
        want = expected_chars.pop_front();
        if (ch !== want.ch) begin
          report_mismatch($sformatf("char 0x%02h, expected 0x%02h", ch, want.ch));
        end
        if (last !== want.last) begin
          report_mismatch($sformatf("tlast %0b on char 0x%02h, expected %0b",
                                    last, ch, want.last));
        end
      end
    endtask

    function int unsigned pending();
      return expected_chars.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;   // [7:0] format_char, [39:8] arg_value
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;   // [7:0] out_char
  logic        m_axis_tlast;   // last_of_run

  formatter_scoreboard sb;
  int unsigned         sent_count;
  int unsigned         burst_left;
  int unsigned         idle_cycles;

  printf_integer_formatter dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata),
    .m_axis_tlast_o (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Note every accepted format byte, check every accepted character
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      sb.note_input(s_axis_tdata[7:0], s_axis_tdata[39:8]);
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_output(m_axis_tdata, m_axis_tlast);
    end
  end

  // Hang detection: count cycles in which no item moves on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Receiver: switch between stall patterns, and hold off once for a long stretch
  // while the sender keeps offering, so the block fills and stops taking input.
  initial begin
    int unsigned mode;
    int unsigned mode_left;
    int unsigned beat;
    bit          holdoff_done;
    mode = 0;
    mode_left = 0;
    beat = 0;
    holdoff_done = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!holdoff_done && sent_count >= 100) begin
        holdoff_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLDOFF_LEN) @(negedge clk_i);
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(64, 256);
        end
        mode_left--;
        beat++;
        case (mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= 1'($urandom_range(0, 1));
          2: m_axis_tready <= (beat % 4) != 0;
          default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Offer one item and hold it until accepted; gaps fall between random bursts.
  task automatic send_item(input logic [7:0] fmt, input logic [31:0] arg);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(0, 9)) @(negedge clk_i);
      end
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {arg, fmt};
    do @(posedge clk_i); while (!s_axis_tready);
    burst_left--;
    sent_count++;
  endtask

  task automatic send_text(input string text, input logic [31:0] arg);
    for (int i = 0; i < text.len(); i++) begin
      send_item(text[i], arg);
    end
  endtask

  // Bias the argument toward edges: zero, all ones, the sign bits, small numbers
  function automatic logic [31:0] pick_arg();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return $urandom_range(0, 99);
      4: return {16'($urandom_range(0, 65535)), 16'h8000};
      5: return {16'(~$urandom_range(0, 15)), 16'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [7:0] pick_digit(input int unsigned lo);
    return 8'(pfi_pkg::CH_ZERO + $urandom_range(lo, 9));
  endfunction

  // One specifier, mostly well-formed: %, flags, width, modifiers, conversion
  task automatic send_spec();
    logic [7:0] convs[9];
    logic [7:0] mods[4];
    logic [7:0] conv;
    convs = '{pfi_pkg::CH_CONV_D, pfi_pkg::CH_CONV_I, pfi_pkg::CH_CONV_U,
              pfi_pkg::CH_CONV_O, pfi_pkg::CH_CONV_X, pfi_pkg::CH_CONV_UX,
              pfi_pkg::CH_CONV_P, pfi_pkg::CH_CONV_N, pfi_pkg::CH_CONV_C};
    mods = '{pfi_pkg::CH_MOD_F, pfi_pkg::CH_MOD_N, pfi_pkg::CH_MOD_L, pfi_pkg::CH_MOD_H};
    send_item(pfi_pkg::CH_PERCENT, $urandom);
    if ($urandom_range(0, 2) == 0) begin
      send_item(pfi_pkg::CH_MINUS, $urandom);
      // Rarely a second minus, which drops the spec
      if ($urandom_range(0, 9) == 0) begin
        send_item(pfi_pkg::CH_MINUS, $urandom);
      end
    end
    if ($urandom_range(0, 2) == 0) begin
      send_item(pfi_pkg::CH_ZERO, $urandom);
    end
    case ($urandom_range(0, 11))
      0, 1, 2, 3: ;
      4, 5, 6, 7: send_item(pick_digit(1), $urandom);
      8, 9, 10: begin
        send_item(pick_digit(1), $urandom);
        send_item(pick_digit(0), $urandom);
      end
      default: begin
        // Three digits always run into the width limit
        send_item(pick_digit(1), $urandom);
        send_item(pick_digit(0), $urandom);
        send_item(pick_digit(0), $urandom);
      end
    endcase
    repeat ($urandom_range(0, 2)) send_item(mods[$urandom_range(0, 3)], $urandom);
    if ($urandom_range(0, 11) == 0) begin
      conv = 8'($urandom_range(1, 255));
    end else begin
      conv = convs[$urandom_range(0, 8)];
    end
    send_item(conv, pick_arg());
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    sent_count = 0;
    burst_left = 0;
    sb = new();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: echo of the top byte, %%, double minus, signed extremes
    // with zero and left padding, short modifier, %c of a zero byte, width
    // saturation, the widest octal, a zero byte mid-spec and an unknown conversion.
    send_item(8'hFF, $urandom);
    send_text("%%", 32'h0);
    send_text("%--", 32'h0);
    send_text("%015ld", 32'h8000_0000);
    send_text("%-6hi", 32'h1234_8000);
    send_text("%5c", 32'h0);
    send_text("%99X", 32'hFFFF_FFFF);
    send_text("%o", 32'hFFFF_FFFF);
    send_item(pfi_pkg::CH_PERCENT, $urandom);
    send_item(8'h00, $urandom);
    send_text("%s", 32'h0);

    // Random part: mostly well-formed specifiers, mixed with plain text and noise
    sent_count = 0;
    while (sent_count < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: send_spec();
        6, 7: send_item(8'($urandom_range(8'h20, 8'h7E)), $urandom);
        8: send_item(8'($urandom_range(0, 255)), $urandom);
        default: begin
          send_item(pfi_pkg::CH_PERCENT, $urandom);
          send_item(8'($urandom_range(0, 255)), pick_arg());
        end
      endcase
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;

    // Drain, then watch a while for stray characters
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (sb.error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
